FILE: rtl/lfr_pkg.sv
// shared types, constants and table lookups for the lux reporter
package lfr_pkg;

    localparam int DATA_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int DIVR_W   = 5;
    localparam int SEG_W    = 4;
    localparam int MODE_W   = 3;
    localparam int EXP_W    = 4;
    localparam int MANT_W   = 11;
    localparam int SEG_CNT  = 15;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [BYTE_W-1:0] LUX_SAT_LIMIT = 8'd112;
    localparam logic [DATA_W-1:0] LUX_MAX       = 16'hFFFF;
    localparam logic [DATA_W-1:0] MANT_MAX      = 16'h07FF;
    localparam logic [EXP_W-1:0]  EXP_START     = 4'(16'h3800 >> MANT_W);

    localparam logic [SEG_W-1:0] SEG_LAST       = 4'd14;
    localparam logic [SEG_W-1:0] SEG_FINE_LIMIT = 4'd11;
    localparam logic [SEG_W-1:0] SEG_LOW_LIMIT  = 4'd7;
    localparam logic [SEG_W-1:0] SEG_BASE_MIN   = 4'd1;
    localparam logic [SEG_W-1:0] SEG_SHIFT_ADJ  = 4'd2;

    localparam logic [BYTE_W-1:0] SEG_BOUND [SEG_CNT] = '{
        8'd0, 8'd9, 8'd17, 8'd27, 8'd40, 8'd53, 8'd66, 8'd79,
        8'd88, 8'd96, 8'd101, 8'd106, 8'd109, 8'd112, 8'd255
    };

    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DIV20 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIV10 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV5  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV3  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEG_GO,
        ST_SEG_WAIT,
        ST_LOW_GO,
        ST_LOW_WAIT,
        ST_FIN_GO,
        ST_FIN_WAIT
    } state_t;

    function automatic logic [DIVR_W-1:0] mode_divisor(input logic [MODE_W-1:0] mode);
        logic [DIVR_W-1:0] d;
        unique case (mode)
            MODE_DIV20: d = 5'd20;
            MODE_DIV10: d = 5'd10;
            MODE_DIV5:  d = 5'd5;
            MODE_DIV3:  d = 5'd3;
            default:    d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic mode_active(input logic [MODE_W-1:0] mode);
        return (mode >= MODE_DIV20) && (mode <= MODE_DIV3);
    endfunction

endpackage

FILE: rtl/lfr_in_if.sv
// input channel carrying one brightness sample
interface lfr_in_if;
    logic                          valid;
    logic                          ready;
    logic [lfr_pkg::BYTE_W-1:0]    adc_high;
    logic [lfr_pkg::BYTE_W-1:0]    adc_low;

    modport source (output valid, output adc_high, output adc_low, input ready);
    modport sink   (input valid, input adc_high, input adc_low, output ready);
endinterface

FILE: rtl/lfr_out_if.sv
// output channel carrying one lux report
interface lfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [lfr_pkg::DATA_W-1:0]    lux_value;
    logic [lfr_pkg::DATA_W-1:0]    lux_word;
    logic                          value_differs;
    logic                          send_now;

    modport source (output valid, output lux_value, output lux_word,
                    output value_differs, output send_now, input ready);
    modport sink   (input valid, input lux_value, input lux_word,
                    input value_differs, input send_now, output ready);
endinterface

FILE: rtl/adc_to_lux_float_reporter_top.sv
// top level of the brightness sample to lux reporter
// One sample is handled at a time and yields one report. A serial segment
// search comes first. One or two passes of the shared bit-serial divider
// do the interpolation; each pass has a start state, yields 16 quotient
// bits and then hands off. The second pass is needed only for a high byte
// below 66. A final divider pass computes the send threshold and overlaps
// the float normalization. Saturated samples (high byte 112 or more) skip
// the search and the interpolation. The finished report sits in an output
// register, so the next sample is taken while it waits. That sample stalls
// only at its own report if the previous one is still not taken.
// change_mode (the cfg_wr_en write) is to be written by the user only while
// no transaction is in progress; the block itself does not enforce this.
module adc_to_lux_float_reporter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lfr_pkg::MODE_W-1:0]    cfg_wr_data,
    lfr_in_if.sink                        adc,
    lfr_out_if.source                     lux
);

    lfr_pkg::state_t                     state_reg, state_next;
    logic [lfr_pkg::MODE_W-1:0]          mode_reg;
    logic [lfr_pkg::DATA_W-1:0]          reported_reg, reported_next;
    logic [lfr_pkg::BYTE_W-1:0]          hi_reg, hi_next;
    logic [lfr_pkg::BYTE_W-1:0]          lo_reg, lo_next;
    logic [lfr_pkg::SEG_W-1:0]           n_reg, n_next;
    logic [lfr_pkg::DATA_W-1:0]          lux_reg, lux_next;
    logic [lfr_pkg::DATA_W-1:0]          diff_reg, diff_next;
    logic                                differs_reg, differs_next;
    logic                                out_valid_reg, out_valid_next;
    logic [lfr_pkg::DATA_W-1:0]          out_value_reg, out_value_next;
    logic [lfr_pkg::DATA_W-1:0]          out_word_reg, out_word_next;
    logic                                out_differs_reg, out_differs_next;
    logic                                out_send_reg, out_send_next;

    logic                                in_ready;
    logic                                div_start, div_busy;
    logic [lfr_pkg::DATA_W-1:0]          div_dividend, div_quotient;
    logic [lfr_pkg::DIVR_W-1:0]          div_divisor;
    logic                                enc_start, enc_busy;
    logic [lfr_pkg::DATA_W-1:0]          enc_word;

    logic                                seg_hit;
    logic [lfr_pkg::BYTE_W-1:0]          seg_prev;
    logic [lfr_pkg::BYTE_W-1:0]          seg_rest;
    logic [lfr_pkg::DIVR_W-1:0]          seg_width;
    logic [lfr_pkg::SEG_W-1:0]           seg_shift;
    logic [lfr_pkg::DATA_W-1:0]          seg_dividend;
    logic [lfr_pkg::DATA_W-1:0]          low_dividend;
    logic [lfr_pkg::DATA_W-1:0]          seg_base;
    logic [lfr_pkg::DATA_W-1:0]          seg_add;
    logic [lfr_pkg::DATA_W-1:0]          thr;
    logic                                send;
    logic                                fin_ready;

    // segment lookup
    assign seg_hit   = (n_reg < lfr_pkg::SEG_LAST) && (hi_reg >= lfr_pkg::SEG_BOUND[n_reg]);
    assign seg_prev  = lfr_pkg::SEG_BOUND[n_reg - 1'b1];
    assign seg_rest  = hi_reg - seg_prev;
    assign seg_width = lfr_pkg::DIVR_W'(lfr_pkg::SEG_BOUND[n_reg] - seg_prev);
    assign seg_shift = (n_reg < lfr_pkg::SEG_FINE_LIMIT) ? n_reg + lfr_pkg::SEG_SHIFT_ADJ
                                                         : n_reg - lfr_pkg::SEG_SHIFT_ADJ;
    assign seg_dividend = {8'd0, seg_rest} << seg_shift;
    assign low_dividend = {8'd0, lo_reg} << (n_reg + lfr_pkg::SEG_SHIFT_ADJ);
    assign seg_base = (n_reg <= lfr_pkg::SEG_BASE_MIN) ? '0
                    : (lfr_pkg::DATA_W'(1) << (n_reg + 1'b1));
    assign seg_add  = (n_reg < lfr_pkg::SEG_FINE_LIMIT) ? div_quotient
                    : {div_quotient[lfr_pkg::DATA_W-5:0], 4'd0};

    // send threshold
    assign thr  = (div_quotient == '0) ? lfr_pkg::DATA_W'(1) : div_quotient;
    assign send = lfr_pkg::mode_active(mode_reg) && differs_reg && (diff_reg >= thr);
    assign fin_ready = !div_busy && !enc_busy && (!out_valid_reg || lux.ready);

    lfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    lfr_fenc u_fenc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (enc_start),
        .lux   (lux_reg),
        .busy  (enc_busy),
        .word  (enc_word)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfr_pkg::ST_IDLE:
            begin
                if (adc.valid)
                begin
                    state_next = (adc.adc_high >= lfr_pkg::LUX_SAT_LIMIT) ? lfr_pkg::ST_FIN_GO
                                                                         : lfr_pkg::ST_SEARCH;
                end
            end
            lfr_pkg::ST_SEARCH:
            begin
                if (!seg_hit)
                begin
                    state_next = lfr_pkg::ST_SEG_GO;
                end
            end
            lfr_pkg::ST_SEG_GO:
            begin
                state_next = lfr_pkg::ST_SEG_WAIT;
            end
            lfr_pkg::ST_SEG_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = (n_reg < lfr_pkg::SEG_LOW_LIMIT) ? lfr_pkg::ST_LOW_GO
                                                                  : lfr_pkg::ST_FIN_GO;
                end
            end
            lfr_pkg::ST_LOW_GO:
            begin
                state_next = lfr_pkg::ST_LOW_WAIT;
            end
            lfr_pkg::ST_LOW_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = lfr_pkg::ST_FIN_GO;
                end
            end
            lfr_pkg::ST_FIN_GO:
            begin
                state_next = lfr_pkg::ST_FIN_WAIT;
            end
            lfr_pkg::ST_FIN_WAIT:
            begin
                if (fin_ready)
                begin
                    state_next = lfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;
        enc_start        = 1'b0;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        n_next           = n_reg;
        lux_next         = lux_reg;
        diff_next        = diff_reg;
        differs_next     = differs_reg;
        reported_next    = reported_reg;
        out_value_next   = out_value_reg;
        out_word_next    = out_word_reg;
        out_differs_next = out_differs_reg;
        out_send_next    = out_send_reg;
        out_valid_next   = out_valid_reg && !lux.ready;
        unique case (state_reg)
            lfr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (adc.valid)
                begin
                    hi_next  = adc.adc_high;
                    lo_next  = adc.adc_low;
                    n_next   = '0;
                    lux_next = lfr_pkg::LUX_MAX;
                end
            end
            lfr_pkg::ST_SEARCH:
            begin
                if (seg_hit)
                begin
                    n_next = n_reg + 1'b1;
                end
            end
            lfr_pkg::ST_SEG_GO:
            begin
                div_start    = 1'b1;
                div_dividend = seg_dividend;
                div_divisor  = seg_width;
            end
            lfr_pkg::ST_SEG_WAIT:
            begin
                if (!div_busy)
                begin
                    lux_next = seg_base + seg_add;
                end
            end
            lfr_pkg::ST_LOW_GO:
            begin
                div_start    = 1'b1;
                div_dividend = low_dividend;
                div_divisor  = seg_width;
            end
            lfr_pkg::ST_LOW_WAIT:
            begin
                if (!div_busy)
                begin
                    lux_next = lux_reg + {8'd0, div_quotient[lfr_pkg::DATA_W-1:8]};
                end
            end
            lfr_pkg::ST_FIN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = reported_reg;
                div_divisor  = lfr_pkg::mode_divisor(mode_reg);
                enc_start    = 1'b1;
                differs_next = lux_reg != reported_reg;
                diff_next    = (lux_reg > reported_reg) ? lux_reg - reported_reg
                                                        : reported_reg - lux_reg;
            end
            lfr_pkg::ST_FIN_WAIT:
            begin
                if (fin_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = lux_reg;
                    out_word_next    = enc_word;
                    out_differs_next = differs_reg;
                    out_send_next    = send;
                    if (send)
                    begin
                        reported_next = lux_reg;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfr_pkg::ST_IDLE;
            mode_reg      <= lfr_pkg::MODE_OFF;
            reported_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg          <= hi_next;
        lo_reg          <= lo_next;
        n_reg           <= n_next;
        lux_reg         <= lux_next;
        diff_reg        <= diff_next;
        differs_reg     <= differs_next;
        out_value_reg   <= out_value_next;
        out_word_reg    <= out_word_next;
        out_differs_reg <= out_differs_next;
        out_send_reg    <= out_send_next;
    end

    assign adc.ready         = in_ready;
    assign lux.valid         = out_valid_reg;
    assign lux.lux_value     = out_value_reg;
    assign lux.lux_word      = out_word_reg;
    assign lux.value_differs = out_differs_reg;
    assign lux.send_now      = out_send_reg;

endmodule

FILE: rtl/lfr_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module lfr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfr_pkg::DATA_W-1:0]    dividend,
    input  logic [lfr_pkg::DIVR_W-1:0]    divisor,
    output logic                          busy,
    output logic [lfr_pkg::DATA_W-1:0]    quotient
);

    logic                                busy_reg, busy_next;
    logic [lfr_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lfr_pkg::DATA_W-1:0]          work_reg, work_next;
    logic [lfr_pkg::DIVR_W-1:0]          rem_reg, rem_next;
    logic [lfr_pkg::DIVR_W-1:0]          divr_reg, divr_next;
    logic [lfr_pkg::DIVR_W:0]            trial;
    logic                                fits;

    assign trial = {rem_reg, work_reg[lfr_pkg::DATA_W-1]};
    assign fits  = trial >= {1'b0, divr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        divr_next = divr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = dividend;
            rem_next  = '0;
            divr_next = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[lfr_pkg::DATA_W-2:0], fits};
            rem_next  = fits ? lfr_pkg::DIVR_W'(trial - {1'b0, divr_reg})
                             : trial[lfr_pkg::DIVR_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == lfr_pkg::DIV_CNT_W'(lfr_pkg::DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        divr_reg <= divr_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule

FILE: rtl/lfr_fenc.sv
// bus float encoder, normalizes the mantissa one shift per cycle
module lfr_fenc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfr_pkg::DATA_W-1:0]    lux,
    output logic                          busy,
    output logic [lfr_pkg::DATA_W-1:0]    word
);

    logic                                busy_reg, busy_next;
    logic [lfr_pkg::DATA_W-1:0]          mant_reg, mant_next;
    logic [lfr_pkg::EXP_W-1:0]           exp_reg, exp_next;
    logic [lfr_pkg::DATA_W:0]            scaled;

    assign scaled = {1'b0, lux >> 1} + {1'b0, lux >> 2} + {1'b0, lux >> 5};

    always_comb
    begin
        busy_next = busy_reg;
        mant_next = mant_reg;
        exp_next  = exp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mant_next = scaled[lfr_pkg::DATA_W-1:0];
            exp_next  = lfr_pkg::EXP_START;
        end
        else if (busy_reg)
        begin
            if (mant_reg > lfr_pkg::MANT_MAX)
            begin
                mant_next = mant_reg >> 1;
                exp_next  = exp_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mant_reg <= mant_next;
        exp_reg  <= exp_next;
    end

    assign busy = busy_reg;
    assign word = {1'b0, exp_reg, mant_reg[lfr_pkg::MANT_W-1:0]};

endmodule
